FILE: design/cdrc_pkg.sv
// cdrc_pkg: shared types and constants of the cd-rom host register block
// used by cdrc_ctrl, cdrc_dp and cdrom_controller_host_registers
// no dependencies
package cdrc_pkg;

  localparam logic [1:0] REG_STATUS = 2'd0;
  localparam logic [1:0] REG_CMD    = 2'd1;
  localparam logic [1:0] REG_PARAM  = 2'd2;
  localparam logic [1:0] REG_IRQ    = 2'd3;

  localparam logic [1:0] BANK0 = 2'd0;
  localparam logic [1:0] BANK1 = 2'd1;

  localparam logic [7:0] CMD_GETSTAT  = 8'h01;
  localparam logic [7:0] CMD_TEST     = 8'h19;
  localparam logic [7:0] TEST_VERSION = 8'h20;

  localparam logic [7:0] STAT_BYTE = 8'h10;
  localparam logic [2:0] FLAGS_ACK = 3'd3;

  typedef enum logic [2:0] {
    PB_GETSTAT,
    PB_VER0,
    PB_VER1,
    PB_VER2,
    PB_VER3
  } push_byte_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP,
    ST_TEST,
    ST_VER,
    ST_DONE
  } cdrc_state_e;

  typedef struct packed {
    logic       cap_item;
    logic       exec;
    logic       pop_resp;
    logic       pop_param;
    logic       push_resp;
    push_byte_e push_sel;
    logic       set_flags;
    logic       load_pop;
    logic       load_out;
  } cdrc_cmd_t;

  typedef struct packed {
    logic cmd_write;
    logic resp_read;
    logic op_getstat;
    logic op_test;
    logic sub_match;
  } cdrc_stat_t;

  function automatic logic [7:0] push_byte(push_byte_e sel);
    logic [7:0] b;
    b = 8'h00;
    unique case (sel)
      PB_GETSTAT: b = STAT_BYTE;
      PB_VER0:    b = 8'h98;
      PB_VER1:    b = 8'h06;
      PB_VER2:    b = 8'h10;
      PB_VER3:    b = 8'hC3;
      default:    b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: design/cdrom_controller_host_registers.sv
// cdrom_controller_host_registers: top level of the cd-rom host register block
// depends on cdrc_pkg, cdrc_ctrl, cdrc_dp (with cdrc_fifo)
//
// channel  | direction | tdata / tuser
// s_axis   | in        | tdata: address[1:0], write_data[9:2]; tuser: mode
// m_axis   | out       | tdata: read_data[7:0], irq_request[8]
//
// an access steps from accept through decode to the output register, its result
// passing through the result register; a response pop adds the pop state, any test
// command adds the test state, and a test version answer also adds one push state per
// reply byte (one response queue write port, one byte per cycle)
// reset clears control state and both queues at once via per-entry valid bits
// a new access is accepted while the previous result waits on m_axis_tready_i
module cdrom_controller_host_registers #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // address, write_data, zero pad
  input  logic        s_axis_tuser_i,   // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // read_data, irq_request, zero pad
);
  import cdrc_pkg::*;

  cdrc_cmd_t  cmd;
  cdrc_stat_t stat;
  logic [7:0] read_data;
  logic       irq_request;

  cdrc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cdrc_dp #(.FIFO_DEPTH(FIFO_DEPTH)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (s_axis_tuser_i),
    .address_i     (s_axis_tdata_i[1:0]),
    .write_data_i  (s_axis_tdata_i[9:2]),
    .stat_o        (stat),
    .read_data_o   (read_data),
    .irq_request_o (irq_request)
  );

  assign m_axis_tdata_o = {7'b0, irq_request, read_data};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("output register overwritten while a result waits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("second beat taken before the access was processed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result appeared without an access in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_resp |-> !(cmd.pop_resp || cmd.pop_param))
    else $error("queue push and pop in the same cycle");

endmodule

FILE: design/cdrc_fifo.sv
// cdrc_fifo: byte queue with wrapping pointers, memory and per-entry valid bits
// push and pop are unchecked; read data is registered on pop
// no package dependencies
module cdrc_fifo #(
  parameter int unsigned DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] push_data_i,
  input  logic       pop_i,
  input  logic       clear_i,
  output logic [7:0] rd_data_o,
  output logic       empty_o,
  output logic       full_o
);

  localparam int unsigned PTR_W = $clog2(2 * DEPTH);
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(2 * DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_HALF = PTR_W'(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [7:0]       rdata_q;
  logic             rvalid_q;
  logic             wr_hi, rd_hi;
  logic [IDX_W-1:0] wr_idx, rd_idx;

  assign wr_hi  = (wr_q >= PTR_HALF);
  assign rd_hi  = (rd_q >= PTR_HALF);
  assign wr_idx = wr_hi ? IDX_W'(wr_q - PTR_HALF) : IDX_W'(wr_q);
  assign rd_idx = rd_hi ? IDX_W'(rd_q - PTR_HALF) : IDX_W'(rd_q);

  assign empty_o   = (wr_q == rd_q);
  assign full_o    = (wr_idx == rd_idx) && (wr_hi != rd_hi);
  assign rd_data_o = rvalid_q ? rdata_q : 8'h00;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q     <= '0;
      rd_q     <= '0;
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else if (clear_i) begin
      wr_q    <= '0;
      rd_q    <= '0;
      valid_q <= '0;
    end else begin
      if (push_i) begin
        wr_q            <= (wr_q == PTR_LAST) ? '0 : wr_q + 1'b1;
        valid_q[wr_idx] <= 1'b1;
      end
      if (pop_i) begin
        rd_q     <= (rd_q == PTR_LAST) ? '0 : rd_q + 1'b1;
        rvalid_q <= valid_q[rd_idx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_idx] <= push_data_i;
    end
    if (pop_i) begin
      rdata_q <= mem[rd_idx];
    end
  end

endmodule

FILE: design/cdrc_dp.sv
// cdrc_dp: host registers, parameter and response queues, result and output registers
// depends on cdrc_pkg and cdrc_fifo
module cdrc_dp #(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cdrc_pkg::cdrc_cmd_t  cmd_i,
  input  logic                 mode_i,
  input  logic [1:0]           address_i,
  input  logic [7:0]           write_data_i,
  output cdrc_pkg::cdrc_stat_t stat_o,
  output logic [7:0]           read_data_o,
  output logic                 irq_request_o
);
  import cdrc_pkg::*;

  logic       mode_q;
  logic [1:0] addr_q;
  logic [7:0] wdata_q;
  logic [1:0] bank_q;
  logic [4:0] irq_en_q;
  logic [2:0] flags_q;
  logic       start_q;
  logic [7:0] res_data_q;
  logic       res_irq_q;
  logic [7:0] out_data_q;
  logic       out_irq_q;

  logic [7:0] param_rdata, resp_rdata, rd_mux;
  logic       param_empty, param_full, resp_empty, resp_full;
  logic       wr_param, wr_ctrl;

  assign wr_param = cmd_i.exec && mode_q && (addr_q == REG_PARAM) && (bank_q == BANK0);
  assign wr_ctrl  = cmd_i.exec && mode_q && (addr_q == REG_IRQ) && (bank_q == BANK1);

  cdrc_fifo #(.DEPTH(FIFO_DEPTH)) u_param_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (wr_param),
    .push_data_i (wdata_q),
    .pop_i       (cmd_i.pop_param),
    .clear_i     (wr_ctrl && wdata_q[6]),
    .rd_data_o   (param_rdata),
    .empty_o     (param_empty),
    .full_o      (param_full)
  );

  cdrc_fifo #(.DEPTH(FIFO_DEPTH)) u_resp_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (cmd_i.push_resp),
    .push_data_i (push_byte(cmd_i.push_sel)),
    .pop_i       (cmd_i.pop_resp),
    .clear_i     (1'b0),
    .rd_data_o   (resp_rdata),
    .empty_o     (resp_empty),
    .full_o      (resp_full)
  );

  always_comb begin
    rd_mux = 8'h00;
    unique case (addr_q)
      REG_STATUS: rd_mux = {2'b00, resp_empty, ~param_full, param_empty, 1'b0, bank_q};
      REG_CMD:    rd_mux = 8'h00;
      REG_PARAM:  rd_mux = 8'h00;
      REG_IRQ:    rd_mux = bank_q[0] ? {3'b111, start_q, 1'b0, flags_q} : {3'b000, irq_en_q};
      default:    rd_mux = 8'h00;
    endcase
  end

  assign stat_o.cmd_write  = mode_q && (addr_q == REG_CMD) && (bank_q == BANK0);
  assign stat_o.resp_read  = !mode_q && (addr_q == REG_CMD);
  assign stat_o.op_getstat = (wdata_q == CMD_GETSTAT);
  assign stat_o.op_test    = (wdata_q == CMD_TEST);
  assign stat_o.sub_match  = (param_rdata == TEST_VERSION);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_item) begin
      mode_q  <= mode_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
    end
    if (cmd_i.exec) begin
      res_data_q <= mode_q ? 8'h00 : rd_mux;
      res_irq_q  <= mode_q && (addr_q == REG_CMD) && (bank_q == BANK0);
    end else if (cmd_i.load_pop) begin
      res_data_q <= resp_rdata;
    end
    if (cmd_i.load_out) begin
      out_data_q <= res_data_q;
      out_irq_q  <= res_irq_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q   <= '0;
      irq_en_q <= '0;
      flags_q  <= '0;
      start_q  <= 1'b0;
    end else begin
      if (cmd_i.exec && mode_q) begin
        if (addr_q == REG_STATUS) begin
          bank_q <= wdata_q[1:0];
        end
        if ((addr_q == REG_PARAM) && (bank_q == BANK1)) begin
          irq_en_q <= wdata_q[4:0];
        end
      end
      if (cmd_i.set_flags) begin
        flags_q <= FLAGS_ACK;
      end else if (wr_ctrl) begin
        flags_q <= flags_q & ~wdata_q[2:0];
        start_q <= wdata_q[4];
      end
    end
  end

  assign read_data_o   = out_data_q;
  assign irq_request_o = out_irq_q | (resp_full & 1'b0);

endmodule

FILE: design/cdrc_ctrl.sv
// cdrc_ctrl: access sequencer, steps each bus access through decode, queue and output
// depends on cdrc_pkg
module cdrc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  cdrc_pkg::cdrc_stat_t stat_i,
  output cdrc_pkg::cdrc_cmd_t  cmd_o
);
  import cdrc_pkg::*;

  cdrc_state_e state_q, state_d;
  logic [1:0]  ver_cnt_q, ver_cnt_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ver_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ver_cnt_q   <= ver_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ver_cnt_d   = ver_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.push_sel = PB_GETSTAT;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap_item = 1'b1;
          state_d        = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.exec = 1'b1;
        priority if (stat_i.resp_read) begin
          cmd_o.pop_resp = 1'b1;
          state_d        = ST_POP;
        end else if (stat_i.cmd_write && stat_i.op_getstat) begin
          cmd_o.push_resp = 1'b1;
          cmd_o.push_sel  = PB_GETSTAT;
          cmd_o.set_flags = 1'b1;
          state_d         = ST_DONE;
        end else if (stat_i.cmd_write && stat_i.op_test) begin
          cmd_o.pop_param = 1'b1;
          state_d         = ST_TEST;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_POP: begin
        cmd_o.load_pop = 1'b1;
        state_d        = ST_DONE;
      end
      ST_TEST: begin
        ver_cnt_d = '0;
        state_d   = stat_i.sub_match ? ST_VER : ST_DONE;
      end
      ST_VER: begin
        cmd_o.push_resp = 1'b1;
        unique case (ver_cnt_q)
          2'd0:    cmd_o.push_sel = PB_VER0;
          2'd1:    cmd_o.push_sel = PB_VER1;
          2'd2:    cmd_o.push_sel = PB_VER2;
          2'd3:    cmd_o.push_sel = PB_VER3;
          default: cmd_o.push_sel = PB_VER0;
        endcase
        ver_cnt_d = ver_cnt_q + 1'b1;
        if (ver_cnt_q == 2'd3) begin
          cmd_o.set_flags = 1'b1;
          state_d         = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: dv/tb.sv
// tb: self-checking bench for cdrom_controller_host_registers over its two stream ports
// predicts every read byte and interrupt request from a bit-exact copy of the register state
// depends on cdrc_pkg and the design sources
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdrc_pkg::*;

  localparam int DEPTH        = 16;
  localparam int DIRECTED_N   = 25;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  localparam logic ACC_READ  = 1'b0;
  localparam logic ACC_WRITE = 1'b1;

  localparam logic [4:0] IRQ_EN_MASK = 5'h1F;
  localparam logic [2:0] FLAGS_TOP   = 3'b111;
  localparam int         CLEAR_BIT   = 6;
  localparam int         START_BIT   = 4;

  localparam logic [7:0] VERSION_REPLY [4] = '{8'h98, 8'h06, 8'h10, 8'hC3};

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
  } reply_t;

  typedef struct packed {
    logic       wr;
    logic [1:0] addr;
    logic [7:0] val;
    logic       typed;
    logic [7:0] rd;
    logic       irq;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i  = 16'h0000;  // address, write_data, zero pad
  logic        s_axis_tuser_i  = 1'b0;      // mode
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;              // read_data, irq_request, zero pad

  logic   row_typed = 1'b0;
  reply_t row_reply = '0;
  logic   hold_req  = 1'b0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int sent_items     = 0;
  int error_count    = 0;

  reply_t pending_replies [$];

  logic [1:0] bank_sel   = 2'd0;
  logic [4:0] irq_en     = 5'd0;
  logic [2:0] resp_flags = 3'd0;
  logic       cmd_start  = 1'b0;
  logic [7:0] param_mem [DEPTH];
  logic [7:0] resp_mem  [DEPTH];
  logic [4:0] param_wp   = 5'd0;
  logic [4:0] param_rp   = 5'd0;
  logic [4:0] resp_wp    = 5'd0;
  logic [4:0] resp_rp    = 5'd0;

  stim_row_t directed_rows [DIRECTED_N] = '{
    '{ACC_READ,  REG_STATUS, 8'h00,        1'b1, 8'h38, 1'b0},
    '{ACC_READ,  REG_PARAM,  8'h00,        1'b1, 8'h00, 1'b0},
    '{ACC_READ,  REG_IRQ,    8'h00,        1'b1, 8'h00, 1'b0},
    '{ACC_READ,  REG_CMD,    8'h00,        1'b1, 8'h00, 1'b0},
    '{ACC_WRITE, REG_CMD,    CMD_GETSTAT,  1'b1, 8'h00, 1'b1},
    '{ACC_READ,  REG_STATUS, 8'h00,        1'b0, 8'h00, 1'b0},
    '{ACC_READ,  REG_CMD,    8'h00,        1'b0, 8'h00, 1'b0},
    '{ACC_WRITE, REG_STATUS, 8'h01,        1'b1, 8'h00, 1'b0},
    '{ACC_READ,  REG_IRQ,    8'h00,        1'b0, 8'h00, 1'b0},
    '{ACC_WRITE, REG_PARAM,  8'hFF,        1'b0, 8'h00, 1'b0},
    '{ACC_WRITE, REG_IRQ,    8'hD7,        1'b0, 8'h00, 1'b0},
    '{ACC_READ,  REG_IRQ,    8'h00,        1'b0, 8'h00, 1'b0},
    '{ACC_WRITE, REG_STATUS, 8'hFE,        1'b0, 8'h00, 1'b0},
    '{ACC_READ,  REG_IRQ,    8'hFF,        1'b0, 8'h00, 1'b0},
    '{ACC_WRITE, REG_STATUS, 8'h00,        1'b0, 8'h00, 1'b0},
    '{ACC_WRITE, REG_PARAM,  TEST_VERSION, 1'b0, 8'h00, 1'b0},
    '{ACC_WRITE, REG_CMD,    CMD_TEST,     1'b1, 8'h00, 1'b1},
    '{ACC_READ,  REG_CMD,    8'h00,        1'b0, 8'h00, 1'b0},
    '{ACC_READ,  REG_CMD,    8'h00,        1'b0, 8'h00, 1'b0},
    '{ACC_READ,  REG_CMD,    8'h00,        1'b0, 8'h00, 1'b0},
    '{ACC_READ,  REG_CMD,    8'h00,        1'b0, 8'h00, 1'b0},
    '{ACC_WRITE, REG_PARAM,  8'h55,        1'b0, 8'h00, 1'b0},
    '{ACC_WRITE, REG_CMD,    CMD_TEST,     1'b0, 8'h00, 1'b0},
    '{ACC_WRITE, REG_CMD,    8'hFF,        1'b1, 8'h00, 1'b1},
    '{ACC_WRITE, REG_CMD,    CMD_TEST,     1'b0, 8'h00, 1'b0}
  };

  cdrom_controller_host_registers #(
    .FIFO_DEPTH(DEPTH)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void resp_push(logic [7:0] b);
    resp_mem[resp_wp[3:0]] = b;
    resp_wp = resp_wp + 5'd1;
  endfunction

  function automatic reply_t predict_access(logic wr, logic [1:0] addr, logic [7:0] val);
    reply_t     r;
    logic [7:0] sub;
    logic [4:0] fill;
    r = '0;
    if (wr) begin
      case (addr)
        REG_STATUS: bank_sel = val[1:0];
        REG_CMD: begin
          if (bank_sel == BANK0) begin
            r.irq = 1'b1;
            if (val == CMD_GETSTAT) begin
              resp_push(STAT_BYTE);
              resp_flags = FLAGS_ACK;
            end else if (val == CMD_TEST) begin
              sub = param_mem[param_rp[3:0]];
              param_rp = param_rp + 5'd1;
              if (sub == TEST_VERSION) begin
                foreach (VERSION_REPLY[i]) resp_push(VERSION_REPLY[i]);
                resp_flags = FLAGS_ACK;
              end
            end
          end
        end
        REG_PARAM: begin
          if (bank_sel == BANK0) begin
            param_mem[param_wp[3:0]] = val;
            param_wp = param_wp + 5'd1;
          end else if (bank_sel == BANK1) begin
            irq_en = val[4:0] & IRQ_EN_MASK;
          end
        end
        default: begin
          if (bank_sel == BANK1) begin
            resp_flags = resp_flags & ~val[2:0];
            cmd_start = val[START_BIT];
            if (val[CLEAR_BIT]) begin
              foreach (param_mem[i]) param_mem[i] = 8'h00;
              param_wp = 5'd0;
              param_rp = 5'd0;
            end
          end
        end
      endcase
    end else begin
      case (addr)
        REG_STATUS: begin
          fill = param_wp - param_rp;
          r.rd = {2'b00, resp_wp == resp_rp, fill != 5'd16, param_wp == param_rp, 1'b0,
                  bank_sel};
        end
        REG_CMD: begin
          r.rd = resp_mem[resp_rp[3:0]];
          resp_rp = resp_rp + 5'd1;
        end
        REG_PARAM: r.rd = 8'h00;
        default: begin
          if (!bank_sel[0]) r.rd = {3'b000, irq_en};
          else r.rd = {FLAGS_TOP, cmd_start, 1'b0, resp_flags};
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_error(string what, logic [8:0] want, logic [8:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  task automatic send_access(input logic wr, input logic [1:0] addr, input logic [7:0] val,
                             input logic typed = 1'b0, input logic [7:0] rd = 8'h00,
                             input logic irq = 1'b0);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b000000, val, addr};
    s_axis_tuser_i  <= wr;
    row_typed       <= typed;
    row_reply       <= '{rd: rd, irq: irq};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sent_items++;
  endtask

  always @(posedge clk_i) begin : scoreboard
    reply_t want;
    reply_t got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        want = predict_access(s_axis_tuser_i, s_axis_tdata_i[1:0], s_axis_tdata_i[9:2]);
        if (row_typed) want = row_reply;
        pending_replies.push_back(want);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.rd  = m_axis_tdata_o[7:0];
        got.irq = m_axis_tdata_o[8];
        if (pending_replies.size() == 0) begin
          report_error("unexpected beat", 9'h000, {got.rd, got.irq});
        end else begin
          want = pending_replies.pop_front();
          if (got.rd != want.rd) report_error("read_data", {1'b0, want.rd}, {1'b0, got.rd});
          if (got.irq != want.irq)
            report_error("irq_request", {8'h00, want.irq}, {8'h00, got.irq});
        end
      end
    end
  end

  // receiver side: random stalls plus one long hold-off on request
  initial begin : sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req <= 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] val;
    int         src_pct [4];
    int         sink_pct [4];
    src_pct  = '{0, 74, 0, 33};
    sink_pct = '{0, 0, 74, 33};
    foreach (param_mem[i]) begin
      param_mem[i] = 8'h00;
      resp_mem[i]  = 8'h00;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_access(directed_rows[i].wr, directed_rows[i].addr, directed_rows[i].val,
                  directed_rows[i].typed, directed_rows[i].rd, directed_rows[i].irq);

    for (int phase = 0; phase < 4; phase++) begin
      // quiet the sender and let every reply come back between phases
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
      while (pending_replies.size() != 0) @(posedge clk_i);
      src_idle_pct   = src_pct[phase];
      sink_stall_pct = sink_pct[phase];
      if (phase == 0) hold_req <= 1'b1;
      while (sent_items < DIRECTED_N + (phase + 1) * RANDOM_ITEMS / 4) begin
        case ($urandom_range(7))
          0: begin
            val = 8'($urandom);
            if ($urandom_range(1) == 1) val[1:0] = BANK0;
            send_access(ACC_WRITE, REG_STATUS, val);
          end
          1: begin
            // parameter burst, sometimes past full
            val = 8'($urandom);
            val[1:0] = BANK0;
            send_access(ACC_WRITE, REG_STATUS, val);
            repeat ($urandom_range(1, 20)) begin
              val = ($urandom_range(3) == 0) ? TEST_VERSION : 8'($urandom);
              send_access(ACC_WRITE, REG_PARAM, val);
            end
            send_access(ACC_READ, REG_STATUS, 8'($urandom));
          end
          2: begin
            val = 8'($urandom);
            val[1:0] = BANK0;
            send_access(ACC_WRITE, REG_STATUS, val);
            send_access(ACC_WRITE, REG_CMD, CMD_GETSTAT);
            repeat ($urandom_range(0, 3)) send_access(ACC_READ, REG_CMD, 8'($urandom));
            send_access(ACC_READ, REG_STATUS, 8'($urandom));
          end
          3: begin
            val = 8'($urandom);
            val[1:0] = BANK0;
            send_access(ACC_WRITE, REG_STATUS, val);
            if ($urandom_range(3) != 0) begin
              val = ($urandom_range(4) != 0) ? TEST_VERSION : 8'($urandom);
              send_access(ACC_WRITE, REG_PARAM, val);
            end
            send_access(ACC_WRITE, REG_CMD, CMD_TEST);
            repeat ($urandom_range(0, 5)) send_access(ACC_READ, REG_CMD, 8'($urandom));
            send_access(ACC_READ, REG_STATUS, 8'($urandom));
          end
          4: begin
            val = 8'($urandom);
            val[1:0] = BANK1;
            send_access(ACC_WRITE, REG_STATUS, val);
            send_access(ACC_READ, REG_IRQ, 8'($urandom));
            send_access(ACC_WRITE, REG_IRQ, 8'($urandom));
            send_access(ACC_READ, REG_IRQ, 8'($urandom));
            if ($urandom_range(1) == 1) send_access(ACC_WRITE, REG_PARAM, 8'($urandom));
            send_access(ACC_READ, REG_STATUS, 8'($urandom));
          end
          5: begin
            val = 8'($urandom);
            val[1:0] = BANK0;
            send_access(ACC_WRITE, REG_STATUS, val);
            send_access(ACC_WRITE, REG_CMD, 8'($urandom));
          end
          default: begin
            repeat ($urandom_range(1, 4))
              send_access(1'($urandom_range(1)), 2'($urandom_range(3)), 8'($urandom));
          end
        endcase
      end
    end

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
